// ----- hdl/edge_weight_insertion_sort_defines.svh -----
// Assertion macros for the edge weight insertion sort block.
// Used by the top level only; assumes clk_i and rst_ni are in scope.
`ifndef EDGE_WEIGHT_INSERTION_SORT_DEFINES_SVH
`define EDGE_WEIGHT_INSERTION_SORT_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define EWIS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define EWIS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ewis_pkg.sv -----
// Shared types and constants for the edge weight insertion sort block.
// No dependencies; imported by ewis_cell and edge_weight_insertion_sort.
package ewis_pkg;

  localparam int unsigned MaxEdgesDefault = 256;
  localparam int unsigned VertexW         = 10;
  localparam int unsigned WeightW         = 16;
  localparam int unsigned CountOutW       = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_CLEAR
  } cell_cmd_e;

  typedef struct packed {
    logic [VertexW-1:0]        start_vertex;
    logic [VertexW-1:0]        end_vertex;
    logic signed [WeightW-1:0] weight;
  } edge_t;

  typedef struct packed {
    cell_cmd_e cmd;
    edge_t     new_edge;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [VertexW-1:0]        start_vertex;
    logic [VertexW-1:0]        end_vertex;
    logic signed [WeightW-1:0] edge_weight;
  } ewis_in_t;

  typedef struct packed {
    logic                      edge_valid;
    logic [VertexW-1:0]        out_start_vertex;
    logic [VertexW-1:0]        out_end_vertex;
    logic signed [WeightW-1:0] out_weight;
    logic [CountOutW-1:0]      stored_count;
    status_e                   status;
  } ewis_out_t;

endpackage

// ----- hdl/edge_weight_insertion_sort.sv -----
// Channel  | Direction | Signals                                | Payload
// in       | input     | in_valid_i, in_ready_o, in_data_i      | ewis_in_t
// out      | output    | out_valid_o, out_ready_i, out_data_o   | ewis_out_t
//
// One item per cycle: every cell compares the new weight in parallel and
// shifts toward its neighbor in the same cycle; a result is registered and
// appears next cycle. The single output register sets the rate: an item is
// taken whenever that register is empty or being drained in the same cycle.
// Reset empties the chain at once; cell contents are not cleared.
// Top level of the edge weight insertion sort; depends on ewis_pkg,
// ewis_cell and edge_weight_insertion_sort_defines.svh.
`include "edge_weight_insertion_sort_defines.svh"

module edge_weight_insertion_sort
  import ewis_pkg::*;
#(
  parameter int unsigned MaxEdges = MaxEdgesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ewis_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ewis_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MaxEdges + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  ewis_out_t           out_q, out_d;
  cell_ctrl_t          ctrl;
  logic                fire;
  logic                full, empty;
  logic [MaxEdges-1:0] occ;
  logic [MaxEdges-1:0] gt;
  edge_t               cell_edge [MaxEdges];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(MaxEdges));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.cmd                   = CMD_HOLD;
    ctrl.new_edge.start_vertex = in_data_i.start_vertex;
    ctrl.new_edge.end_vertex   = in_data_i.end_vertex;
    ctrl.new_edge.weight       = in_data_i.edge_weight;
    count_d                    = count_q;
    out_d                      = '0;
    out_d.status               = ST_OK;
    if (fire) begin
      unique case (op_e'(in_data_i.opcode))
        OP_INSERT: begin
          if (full) begin
            out_d.status = ST_FULL;  // drop the edge
          end else begin
            ctrl.cmd = CMD_INSERT;
            count_d  = count_q + CntW'(1);
          end
        end
        OP_POP: begin
          if (empty) begin
            out_d.status = ST_EMPTY;
          end else begin
            ctrl.cmd               = CMD_POP;
            count_d                = count_q - CntW'(1);
            out_d.edge_valid       = 1'b1;
            out_d.out_start_vertex = cell_edge[0].start_vertex;
            out_d.out_end_vertex   = cell_edge[0].end_vertex;
            out_d.out_weight       = cell_edge[0].weight;
          end
        end
        OP_CLEAR: begin
          ctrl.cmd = CMD_CLEAR;
          count_d  = '0;
        end
        default: begin
        end
      endcase
    end
    out_d.stored_count = CountOutW'(count_d);
  end

  for (genvar k = 0; k < MaxEdges; k++) begin : g_cell
    logic  prev_occ, prev_gt, next_occ;
    edge_t prev_edge, next_edge;

    if (k == 0) begin : g_head
      assign prev_occ  = 1'b1;
      assign prev_gt   = 1'b0;
      assign prev_edge = '0;
    end else begin : g_body
      assign prev_occ  = occ[k-1];
      assign prev_gt   = gt[k-1];
      assign prev_edge = cell_edge[k-1];
    end

    if (k == MaxEdges - 1) begin : g_tail
      assign next_occ  = 1'b0;
      assign next_edge = '0;
    end else begin : g_link
      assign next_occ  = occ[k+1];
      assign next_edge = cell_edge[k+1];
    end

    ewis_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_occ_i  (prev_occ),
      .prev_gt_i   (prev_gt),
      .prev_edge_i (prev_edge),
      .next_occ_i  (next_occ),
      .next_edge_i (next_edge),
      .occ_o       (occ[k]),
      .gt_o        (gt[k]),
      .edge_o      (cell_edge[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `EWIS_ASSERT(a_occ_count, $countones(occ) == count_q, "occupied cells differ from count")
  `EWIS_ASSERT(a_occ_no_gap, ((occ >> 1) & ~occ) == '0, "gap in occupied cells")
  `EWIS_ASSERT_NEXT(a_pop, ctrl.cmd == CMD_POP, out_valid_q && out_q.edge_valid, "pop gave no edge")

endmodule

// ----- hdl/ewis_cell.sv -----
// One cell of the sorted edge chain: holds one edge and an occupied flag.
// Depends on ewis_pkg for the edge and control types.
module ewis_cell
  import ewis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       prev_occ_i,
  input  logic       prev_gt_i,
  input  edge_t      prev_edge_i,
  input  logic       next_occ_i,
  input  edge_t      next_edge_i,
  output logic       occ_o,
  output logic       gt_o,
  output edge_t      edge_o
);

  logic  occ_q, occ_d;
  edge_t edge_q, edge_d;
  logic  gt;

  // Strictly heavier than the new edge, so equal weights stay ahead of it.
  assign gt = occ_q && (edge_q.weight > ctrl_i.new_edge.weight);

  always_comb begin
    occ_d  = occ_q;
    edge_d = edge_q;
    unique case (ctrl_i.cmd)
      CMD_INSERT: begin
        occ_d = occ_q | prev_occ_i;
        if (prev_gt_i) begin
          edge_d = prev_edge_i;
        end else if (gt || (!occ_q && prev_occ_i)) begin
          edge_d = ctrl_i.new_edge;
        end
      end
      CMD_POP: begin
        occ_d  = next_occ_i;
        edge_d = next_edge_i;
      end
      CMD_CLEAR: begin
        occ_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
  end

  assign occ_o  = occ_q;
  assign gt_o   = gt;
  assign edge_o = edge_q;

endmodule
